### sv/mf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; used by mf_median and median_filter_3x3.
package mf_pkg;

  localparam int PIX_W     = 8;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int CNT_W     = 10;
  localparam int REG_W     = 11;
  localparam int IDX_W     = 1;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             start_of_frame;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_value;
    logic             end_of_row;
    logic             end_of_frame;
  } out_t;

  // One window column, sorted: lo <= md <= hi.
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  // Three sorted columns plus the framing flags of the result.
  typedef struct packed {
    col_t [2:0] cols;
    logic       end_of_row;
    logic       end_of_frame;
  } win_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(max2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return min2(min2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    col_t r;
    r.lo = min3(a, b, c);
    r.md = med3(a, b, c);
    r.hi = max3(a, b, c);
    return r;
  endfunction

endpackage

### sv/median_filter_3x3.sv
`timescale 1ns / 1ps
// 3x3 median filter over a raster pixel stream: line store, window and
// counters. Depends on mf_pkg and mf_median.
//
//  port group     direction  flow control         payload
//  in_*           input      in_valid_i/in_stall_o  mf_pkg::in_t
//  out_*          output     out_valid_o/out_stall_i mf_pkg::out_t
//  cfg_*          input      cfg_we_i              index + 11-bit data
//
// One pixel transfers per cycle unless in_stall_o is high; each pixel passes the
// line store read, column sort, two median compare stages and output register.
// The single line store port pair (one read, one write per cycle) sets the rate.
// Reset restores 1024x1024 and clears counters and window; the line store is
// not cleared and needs no clearing pass. A stall on the output backs up through
// the median stages and then holds the input.
module median_filter_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mf_pkg::in_t                    in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mf_pkg::out_t                   out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mf_pkg::IDX_W-1:0]       cfg_index_i,
  input  logic [mf_pkg::REG_W-1:0]       cfg_data_i
);
  import mf_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= REG_W'(MAX_WIDTH);
      height_q <= REG_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the size into the supported range.
  logic [REG_W-1:0] w_eff, h_eff;

  always_comb begin
    w_eff = width_q;
    if (width_q < REG_W'(3))              w_eff = REG_W'(3);
    else if (width_q > REG_W'(MAX_WIDTH)) w_eff = REG_W'(MAX_WIDTH);
    h_eff = height_q;
    if (height_q < REG_W'(3))               h_eff = REG_W'(3);
    else if (height_q > REG_W'(MAX_HEIGHT)) h_eff = REG_W'(MAX_HEIGHT);
  end

  // Stage 1 control: item waiting on its line store read data.
  logic             s1_v_q;
  logic             s1_emit_q, s1_eor_q, s1_eof_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             fwd_q;
  logic [PIX_W-1:0] fwd_top_q, fwd_mid_q;
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] s1_top, s1_mid;
  logic             s1_adv, accept, med_stall;

  // Row and column counters.
  logic [CNT_W-1:0] col_q, row_q, col_d, row_d, col_cur, row_cur;
  logic             last_col, last_row, emit;

  always_comb begin
    col_cur  = in_data_i.start_of_frame ? '0 : col_q;
    row_cur  = in_data_i.start_of_frame ? '0 : row_q;
    last_col = {1'b0, col_cur} >= (w_eff - REG_W'(1));
    last_row = {1'b0, row_cur} >= (h_eff - REG_W'(1));
    emit     = (col_cur >= CNT_W'(2)) && (row_cur >= CNT_W'(2));
    col_d    = col_cur + CNT_W'(1);
    row_d    = row_cur;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_cur + CNT_W'(1);
    end
  end

  assign s1_adv     = s1_v_q && !(s1_emit_q && med_stall);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept)      s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
    end
  end

  // Hold the item's payload and forward when the write ahead hits the same entry.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= ADDR_W'(col_cur);
      s1_pix_q  <= in_data_i.pixel_value;
      s1_emit_q <= emit;
      s1_eor_q  <= last_col;
      s1_eof_q  <= last_col && last_row;
      fwd_q     <= s1_adv && (s1_addr_q == ADDR_W'(col_cur));
      fwd_top_q <= s1_mid;
      fwd_mid_q <= s1_pix_q;
    end
  end

  // Line store: each entry holds {upper row, middle row} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= line_mem[ADDR_W'(col_cur)];
    if (s1_adv) line_mem[s1_addr_q] <= {s1_mid, s1_pix_q};
  end

  assign s1_top = fwd_q ? fwd_top_q : rd_q[2*PIX_W-1:PIX_W];
  assign s1_mid = fwd_q ? fwd_mid_q : rd_q[PIX_W-1:0];

  // Window of the two previous columns, each kept sorted.
  col_t col2_q, col1_q, col_new;
  win_t win;

  assign col_new = sort3(s1_top, s1_mid, s1_pix_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col2_q <= '0;
      col1_q <= '0;
    end else if (s1_adv) begin
      col2_q <= col1_q;
      col1_q <= col_new;
    end
  end

  always_comb begin
    win.cols[0]      = col2_q;
    win.cols[1]      = col1_q;
    win.cols[2]      = col_new;
    win.end_of_row   = s1_eor_q;
    win.end_of_frame = s1_eof_q;
  end

  mf_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (s1_v_q && s1_emit_q),
    .win_stall_o (med_stall),
    .win_i       (win),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/mf_median.sv
`timescale 1ns / 1ps
// Median of a 3x3 window from three sorted columns, in two compare stages
// plus an output register. Depends on mf_pkg.
module mf_median (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         win_valid_i,
  output logic         win_stall_o,
  input  mf_pkg::win_t win_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output mf_pkg::out_t out_data_o
);
  import mf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
    logic             end_of_row;
    logic             end_of_frame;
  } cand_t;

  logic  s2_v_q, s3_v_q, out_v_q;
  win_t  s2_q;
  cand_t s3_q, s3_d;
  out_t  out_q, out_d;
  logic  out_rdy, s3_rdy, s2_rdy;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign s3_rdy  = !s3_v_q || out_rdy;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign win_stall_o = !s2_rdy;

  // Max of the lows, median of the medians, min of the highs.
  always_comb begin
    s3_d.lo = max3(s2_q.cols[0].lo, s2_q.cols[1].lo, s2_q.cols[2].lo);
    s3_d.md = med3(s2_q.cols[0].md, s2_q.cols[1].md, s2_q.cols[2].md);
    s3_d.hi = min3(s2_q.cols[0].hi, s2_q.cols[1].hi, s2_q.cols[2].hi);
    s3_d.end_of_row   = s2_q.end_of_row;
    s3_d.end_of_frame = s2_q.end_of_frame;
  end

  always_comb begin
    out_d.median_value = med3(s3_q.lo, s3_q.md, s3_q.hi);
    out_d.end_of_row   = s3_q.end_of_row;
    out_d.end_of_frame = s3_q.end_of_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy)  s2_v_q  <= win_valid_i;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && win_valid_i) s2_q  <= win_i;
    if (s3_rdy && s2_v_q)      s3_q  <= s3_d;
    if (out_rdy && s3_v_q)     out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for median_filter_3x3: drives pixel frames of many sizes and
// compares every median and framing flag with a cycle-free model kept in the bench.
// Depends on mf_pkg and the median_filter_3x3 RTL.
module testbench;
  import mf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;   // lets the result pipeline drain, with slack
  localparam int HOLD_CYCLES    = 250;
  localparam int RANDOM_TARGET  = 650;

  typedef enum int {TEX_NOISE, TEX_EXTREMES, TEX_BAND, TEX_RAMP} texture_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;

  // One row of the directed stimulus; want is only meaningful when typed is set.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             sof;
    logic             typed;
    out_t             want;
  } step_t;

  localparam out_t NO_RES = '0;
  localparam int   DIR_N  = 22;
  // Two 3x3 frames at clamped sizes, the second reached by wrap-around (no flag),
  // then a short run that restarts the frame twice.
  localparam step_t DIRECTED [DIR_N] = '{
    '{8'hFF, 1'b1, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{8'h5A, 1'b0, 1'b0, NO_RES}, '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h81, 1'b1, 1'b0, NO_RES}, '{8'h7E, 1'b1, 1'b0, NO_RES}
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_t              in_data   = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  reg_idx_e         cfg_index = REG_IMAGE_WIDTH;
  logic [REG_W-1:0] cfg_data  = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  out_t             out_data_o;

  median_filter_3x3 u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Filter state as the bench sees it: line stores with a filled marker per entry,
  // the two past window columns, the raster position and the size registers.
  logic [PIX_W-1:0] upper_row [MAX_WIDTH];
  logic [PIX_W-1:0] middle_row [MAX_WIDTH];
  bit               upper_filled [MAX_WIDTH];
  bit               middle_filled [MAX_WIDTH];
  logic [PIX_W-1:0] past_cols [6];   // [0..2] two columns back, [3..5] one back
  bit [9:0]         col_pos;
  bit [9:0]         row_pos;
  logic [REG_W-1:0] width_reg  = 11'd1024;
  logic [REG_W-1:0] height_reg = 11'd1024;

  out_t medians_due [$];
  int   mismatches     = 0;
  int   medians_seen   = 0;
  int   pixels_sent    = 0;
  int   settings_used  = 0;
  int   gap_pct        = 0;
  int   stall_pct      = 0;
  bit   hold_request   = 1'b0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;

  function automatic int clamp_size(input logic [REG_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Fifth smallest of nine: the value with at most four below it and at
  // least five at or below it.
  function automatic logic [PIX_W-1:0] median_of_nine(input logic [PIX_W-1:0] v [9]);
    int below;
    int same;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      same  = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        else if (v[j] == v[i]) same++;
      end
      if (below <= 4 && below + same > 4) return v[i];
    end
    return v[0];
  endfunction

  // Advance the filter by one pixel; returns 1 when the pixel completes a window.
  function automatic bit filter_pixel(input in_t px, output out_t res);
    int               w;
    int               h;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] hood [9];
    bit               last_col;
    bit               last_row;
    bit               fired;
    w     = clamp_size(width_reg, MAX_WIDTH);
    h     = clamp_size(height_reg, MAX_HEIGHT);
    fired = 1'b0;
    res   = '0;
    if (px.start_of_frame) begin
      col_pos = '0;
      row_pos = '0;
    end
    top = upper_row[col_pos];
    mid = middle_row[col_pos];
    upper_filled[col_pos]  = middle_filled[col_pos];
    upper_row[col_pos]     = mid;
    middle_row[col_pos]    = px.pixel_value;
    middle_filled[col_pos] = 1'b1;
    last_col = int'(col_pos) >= w - 1;
    last_row = int'(row_pos) >= h - 1;
    if (col_pos >= 2 && row_pos >= 2) begin
      hood = '{past_cols[0], past_cols[1], past_cols[2], past_cols[3], past_cols[4],
               past_cols[5], top, mid, px.pixel_value};
      res.median_value = median_of_nine(hood);
      res.end_of_row   = last_col;
      res.end_of_frame = last_col && last_row;
      fired = 1'b1;
    end
    past_cols[0] = past_cols[3];
    past_cols[1] = past_cols[4];
    past_cols[2] = past_cols[5];
    past_cols[3] = top;
    past_cols[4] = mid;
    past_cols[5] = px.pixel_value;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? 10'd0 : row_pos + 10'd1;
    end else begin
      col_pos = col_pos + 10'd1;
    end
    return fired;
  endfunction

  // Number of leading columns whose two line store entries both hold real data.
  function automatic int filled_span();
    for (int i = 0; i < MAX_WIDTH; i++)
      if (!(upper_filled[i] && middle_filled[i])) return i;
    return MAX_WIDTH;
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(input texture_e tex, input int n);
    case (tex)
      TEX_EXTREMES: return $urandom_range(1) ? 8'hFF : 8'h00;
      TEX_BAND:     return 8'd120 + 8'($urandom_range(6));
      TEX_RAMP:     return 8'(n * 7);
      default:      return 8'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Offer one pixel, hold it until the transfer, then record what it should produce.
  task automatic push_pixel(input in_t px, input bit typed, input out_t typed_res);
    out_t res;
    bit   fired;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    pixels_sent++;
    fired = filter_pixel(px, res);
    if (typed) medians_due.push_back(typed_res);
    else if (fired) medians_due.push_back(res);
  endtask

  // Drop valid, wait out every pending median, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [REG_W-1:0] w_raw, input logic [REG_W-1:0] h_raw);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    width_reg = w_raw;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    height_reg = h_raw;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [REG_W-1:0] w_raw, input logic [REG_W-1:0] h_raw,
                           input int n_items, input bit lead_sof, input int sof_pct,
                           input texture_e tex, input idle_e idle, input bit long_hold);
    in_t px;
    bit  restart;
    restart = lead_sof;
    // A wider row in mid-frame would read store entries never filled: restart instead.
    if ((col_pos != 0 || row_pos != 0) && clamp_size(w_raw, MAX_WIDTH) > filled_span())
      restart = 1'b1;
    set_size(w_raw, h_raw);
    case (idle)
      IDLE_SENDER:   begin gap_pct = 45; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 45; end
      IDLE_BOTH:     begin gap_pct = 17; stall_pct = 17; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
    if (long_hold) hold_request = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      px.pixel_value = next_pixel(tex, n);
      if (n == 0) px.start_of_frame = restart;
      else if (col_pos == 0 && row_pos == 0) px.start_of_frame = 1'($urandom_range(1));
      else px.start_of_frame = $urandom_range(99) < sof_pct;
      push_pixel(px, 1'b0, NO_RES);
    end
    settle();
  endtask

  // Receiver: random stall per cycle, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // Result check: every transfer on the output is matched against the oldest median due.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      medians_seen++;
      if (medians_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, median_value %0d",
                                out_data_o.median_value));
      end else begin
        want = medians_due.pop_front();
        if (out_data_o.median_value !== want.median_value)
          flag_mismatch($sformatf("result %0d median_value got %0d want %0d", medians_seen,
                                  out_data_o.median_value, want.median_value));
        if (out_data_o.end_of_row !== want.end_of_row)
          flag_mismatch($sformatf("result %0d end_of_row got %b want %b", medians_seen,
                                  out_data_o.end_of_row, want.end_of_row));
        if (out_data_o.end_of_frame !== want.end_of_frame)
          flag_mismatch($sformatf("result %0d end_of_frame got %b want %b", medians_seen,
                                  out_data_o.end_of_frame, want.end_of_frame));
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d medians still due",
                 quiet_cycles, medians_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_t              px;
    int               random_pixels;
    int               n_items;
    int               area;
    int               shape;
    bit               lead;
    logic [REG_W-1:0] w_raw;
    logic [REG_W-1:0] h_raw;
    random_pixels = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sizes below the minimum clamp to 3x3.
    gap_pct   = 17;
    stall_pct = 17;
    set_size(11'd0, 11'd2);
    for (int k = 0; k < DIR_N; k++) begin
      px.pixel_value    = DIRECTED[k].pix;
      px.start_of_frame = DIRECTED[k].sof;
      push_pixel(px, DIRECTED[k].typed, DIRECTED[k].want);
    end
    settle();

    // Widest row (write above range clamps to 1024), a run into the first row.
    run_phase(11'd2047, 11'd3, 60, 1'b1, 0, TEX_NOISE,
              idle_e'($urandom_range(3)), 1'b0);
    // Exact upper register values, a short run into the first row.
    run_phase(11'd1024, 11'd1024, 40, 1'b0, 0, TEX_NOISE, IDLE_NONE, 1'b0);
    // Tall frame, then shrink the height mid-frame so the current row becomes the last.
    run_phase(11'd3, 11'd2047, 150, 1'b1, 0, TEX_BAND, idle_e'($urandom_range(3)), 1'b0);
    run_phase(11'd3, 11'd5, 30, 1'b0, 0, TEX_NOISE, IDLE_BOTH, 1'b0);
    // Long receiver hold-off with the sender pushing: the pipeline backs up.
    run_phase(11'd6, 11'd12, 72, 1'b1, 0, TEX_NOISE, IDLE_NONE, 1'b1);

    // Random phases: mostly whole frames, some cut short, some noise with stray flags.
    while (random_pixels < RANDOM_TARGET) begin
      case ($urandom_range(99)) inside
        [0:7]:   w_raw = 11'($urandom_range(2));
        [8:14]:  w_raw = 11'($urandom_range(48, 13));
        default: w_raw = 11'($urandom_range(12, 3));
      endcase
      h_raw = ($urandom_range(99) < 8) ? 11'($urandom_range(2)) : 11'($urandom_range(8, 3));
      area  = clamp_size(w_raw, MAX_WIDTH) * clamp_size(h_raw, MAX_HEIGHT);
      shape = $urandom_range(9);
      lead  = (col_pos != 0 || row_pos != 0) ? 1'b1 : 1'($urandom_range(1));
      if (shape < 6) begin
        n_items = (area > 120) ? area : area * $urandom_range(3, 1);
        run_phase(w_raw, h_raw, n_items, lead, 0, texture_e'($urandom_range(3)),
                  idle_e'($urandom_range(3)), 1'b0);
      end else if (shape < 8) begin
        n_items = $urandom_range(area - 1, 1);
        run_phase(w_raw, h_raw, n_items, 1'b1, 0, texture_e'($urandom_range(3)),
                  idle_e'($urandom_range(3)), 1'b0);
      end else begin
        n_items = $urandom_range(40, 5);
        run_phase(w_raw, h_raw, n_items, 1'b0, 10, TEX_NOISE,
                  idle_e'($urandom_range(3)), 1'b0);
      end
      random_pixels += n_items;
    end

    settle();
    $display("Run covered %0d pixels over %0d size settings, 3x3 up to 1024 wide,",
             pixels_sent, settings_used);
    $display("with clamped sizes, restarts, wrap-around and resizing; %0d medians checked.",
             medians_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
